/* src/cfc_pkg.sv */
// Package for the CRC-16 frame checker: frame layout constants, status codes
// and CRC constants. No dependencies.
`default_nettype none

package cfc_pkg;

   localparam int MaxPayloadDefault = 256;

   localparam int HdrBytes = 6;
   localparam int CrcBytes = 2;
   localparam int PosWidth = 17;
   localparam logic [PosWidth-1:0] PosMax = {PosWidth{1'b1}};

   localparam logic [15:0] CrcInit = 16'hFFFF;
   localparam logic [15:0] CrcPoly = 16'h1021;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BAD_LEN = 2'd1,
      STATUS_BAD_CRC = 2'd2
   } status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_FRAME   = 1'b1
   } kind_type;

endpackage

`default_nettype wire

/* src/cfc_crc_step.sv */
// Byte-parallel CRC-16/CCITT-FALSE update, MSB first.
// Depends on cfc_pkg for the polynomial.
`default_nettype none

module cfc_crc_step
   import cfc_pkg::*;
(
   input  wire logic [15:0] crc_cur,
   input  wire logic [7:0]  data_byte,
   output logic      [15:0] crc_next
);

   always_comb begin
      logic [15:0] c;
      c = crc_cur ^ {data_byte, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      crc_next = c;
   end

endmodule

`default_nettype wire

/* src/crc16_frame_checker_core.sv */
// Top level of the CRC-16 frame checker: header capture, CRC tracking,
// payload pass-through and frame status. Depends on cfc_pkg and cfc_crc_step.
//
// Usage:
//   req_ channel carries one frame byte per word, req_end_of_frame on the
//   last byte. rsp_ channel returns a passed-through payload byte
//   (rsp_result_kind 0) or the frame result (rsp_result_kind 1) with the
//   header fields and status (0 ok, 1 bad length, 2 bad CRC). Header, CRC
//   and trailing bytes give no word.
//   A result is in the output register the cycle after its byte is taken.
//   Throughput: one byte per cycle while req_stall is low; the CRC update
//   is one byte-wide XOR network in the feedback path of the frame state.
//   Stall: req_stall is high while the output register holds a word that
//   rsp_stall keeps; a byte is taken in the same cycle its predecessor's
//   result leaves.
//   Reset: synchronous, active high; clears the frame state (CRC to 0xFFFF)
//   and empties the output register. The frame state also returns to reset
//   values after every end-of-frame byte.
`default_nettype none

module crc16_frame_checker_core
   import cfc_pkg::*;
#(
   parameter int PAYLOAD_LIMIT = MaxPayloadDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_end_of_frame,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_result_kind,
   output logic [7:0]       rsp_payload_byte,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_version,
   output logic [7:0]       rsp_msg_type,
   output logic [7:0]       rsp_sequence_res,
   output logic [7:0]       rsp_command,
   output logic [15:0]      rsp_decl_length
);

   localparam logic [PosWidth-1:0] MaxPay  = PosWidth'(PAYLOAD_LIMIT);
   localparam logic [PosWidth-1:0] HdrPos  = PosWidth'(HdrBytes);
   localparam logic [PosWidth-1:0] MinPos  = PosWidth'(HdrBytes + CrcBytes);

   logic [PosWidth-1:0] pos_ff, pos_in;
   logic [15:0]         crc_ff, crc_in;
   logic [7:0]          ver_ff, ver_in;
   logic [7:0]          typ_ff, typ_in;
   logic [7:0]          seq_ff, seq_in;
   logic [7:0]          cmd_ff, cmd_in;
   logic [15:0]         len_ff, len_in;
   logic [15:0]         rcrc_ff, rcrc_in;

   logic                rsp_valid_ff, rsp_valid_in;
   kind_type            kind_ff, kind_in;
   logic [7:0]          pay_ff, pay_in;
   status_type          status_ff, status_in;
   logic [7:0]          o_ver_ff, o_ver_in;
   logic [7:0]          o_typ_ff, o_typ_in;
   logic [7:0]          o_seq_ff, o_seq_in;
   logic [7:0]          o_cmd_ff, o_cmd_in;
   logic [15:0]         o_len_ff, o_len_in;

   logic                accept;
   logic [15:0]         crc_step;
   logic [PosWidth-1:0] pay_end;
   logic                in_payload;
   logic                has_result;

   cfc_crc_step u_crc (
      .crc_cur   (crc_ff),
      .data_byte (req_rx_byte),
      .crc_next  (crc_step)
   );

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign pay_end   = HdrPos + PosWidth'(len_ff);
   assign in_payload = (pos_ff >= HdrPos) && (pos_ff < pay_end);

   always_comb begin
      pos_in  = pos_ff;
      crc_in  = crc_ff;
      ver_in  = ver_ff;
      typ_in  = typ_ff;
      seq_in  = seq_ff;
      cmd_in  = cmd_ff;
      len_in  = len_ff;
      rcrc_in = rcrc_ff;

      kind_in   = KIND_PAYLOAD;
      pay_in    = 8'h00;
      status_in = STATUS_OK;
      o_ver_in  = 8'h00;
      o_typ_in  = 8'h00;
      o_seq_in  = 8'h00;
      o_cmd_in  = 8'h00;
      o_len_in  = 16'h0000;
      has_result = 1'b0;

      if (pos_ff < HdrPos) begin
         unique case (pos_ff[2:0])
            3'd0: ver_in = req_rx_byte;
            3'd1: typ_in = req_rx_byte;
            3'd2: seq_in = req_rx_byte;
            3'd3: cmd_in = req_rx_byte;
            3'd4: len_in = {len_ff[15:8], req_rx_byte};
            default: len_in = {req_rx_byte, len_ff[7:0]};
         endcase
         crc_in = crc_step;
      end else if (pos_ff < pay_end) begin
         crc_in = crc_step;
      end else if (pos_ff == pay_end) begin
         rcrc_in = {rcrc_ff[15:8], req_rx_byte};
      end else if (pos_ff == pay_end + PosWidth'(1)) begin
         rcrc_in = {req_rx_byte, rcrc_ff[7:0]};
      end

      if (pos_ff != PosMax) begin
         pos_in = pos_ff + PosWidth'(1);
      end

      if (!req_end_of_frame) begin
         if (in_payload && (PosWidth'(len_ff) <= MaxPay)) begin
            has_result = 1'b1;
            pay_in     = req_rx_byte;
         end
      end else begin
         has_result = 1'b1;
         kind_in    = KIND_FRAME;
         if (pos_in < MinPos) begin
            status_in = STATUS_BAD_LEN;
         end else if (PosWidth'(len_in) > MaxPay) begin
            status_in = STATUS_BAD_LEN;
         end else if (pos_in != MinPos + PosWidth'(len_in)) begin
            status_in = STATUS_BAD_LEN;
         end else if (rcrc_in != crc_in) begin
            status_in = STATUS_BAD_CRC;
         end
         o_ver_in = ver_in;
         o_typ_in = typ_in;
         o_seq_in = seq_in;
         o_cmd_in = cmd_in;
         o_len_in = len_in;

         pos_in  = '0;
         crc_in  = CrcInit;
         ver_in  = 8'h00;
         typ_in  = 8'h00;
         seq_in  = 8'h00;
         cmd_in  = 8'h00;
         len_in  = 16'h0000;
         rcrc_in = 16'h0000;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = has_result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         crc_ff       <= CrcInit;
         ver_ff       <= 8'h00;
         typ_ff       <= 8'h00;
         seq_ff       <= 8'h00;
         cmd_ff       <= 8'h00;
         len_ff       <= 16'h0000;
         rcrc_ff      <= 16'h0000;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            pos_ff  <= pos_in;
            crc_ff  <= crc_in;
            ver_ff  <= ver_in;
            typ_ff  <= typ_in;
            seq_ff  <= seq_in;
            cmd_ff  <= cmd_in;
            len_ff  <= len_in;
            rcrc_ff <= rcrc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && has_result) begin
         kind_ff   <= kind_in;
         pay_ff    <= pay_in;
         status_ff <= status_in;
         o_ver_ff  <= o_ver_in;
         o_typ_ff  <= o_typ_in;
         o_seq_ff  <= o_seq_in;
         o_cmd_ff  <= o_cmd_in;
         o_len_ff  <= o_len_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = kind_ff;
   assign rsp_payload_byte   = pay_ff;
   assign rsp_status         = status_ff;
   assign rsp_version        = o_ver_ff;
   assign rsp_msg_type       = o_typ_ff;
   assign rsp_sequence_res   = o_seq_ff;
   assign rsp_command        = o_cmd_ff;
   assign rsp_decl_length    = o_len_ff;

endmodule

`default_nettype wire

/* tb/sv/tb_crc16_frame_checker_core.sv */
// Testbench for crc16_frame_checker_core: sends directed and random frames, predicts every
// passed-through payload word and frame result, and checks them in order.
// Depends on cfc_pkg and the checker RTL.
`timescale 1ns / 100ps

module tb_crc16_frame_checker_core
   import cfc_pkg::*;
();

   localparam int MaxPayload   = MaxPayloadDefault;
   localparam int RandomBytes  = 380;
   localparam int IdleLimit    = 2000;
   localparam int DrainCycles  = 8;

   typedef struct {
      kind_type    kind;
      logic [7:0]  payload_byte;
      status_type  status;
      logic [7:0]  version;
      logic [7:0]  msg_type;
      logic [7:0]  sequence_res;
      logic [7:0]  command;
      logic [15:0] decl_length;
   } frame_word_type;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   class frame_scoreboard;
      int             pos_count;
      logic [15:0]    crc_acc;
      logic [7:0]     cap_version;
      logic [7:0]     cap_type;
      logic [7:0]     cap_seq;
      logic [7:0]     cap_cmd;
      logic [15:0]    cap_len;
      logic [15:0]    trailer_crc;
      frame_word_type expected_words[$];
      int             mismatches;

      function new();
         mismatches = 0;
         restart_frame();
      endfunction

      function void restart_frame();
         pos_count   = 0;
         crc_acc     = CrcInit;
         cap_version = '0;
         cap_type    = '0;
         cap_seq     = '0;
         cap_cmd     = '0;
         cap_len     = '0;
         trailer_crc = '0;
      endfunction

      static function logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
         logic [15:0] c;
         c = crc ^ {b, 8'h00};
         for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
         end
         return c;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      // one accepted byte; queues the word it produces, if any
      function void note_byte(logic [7:0] b, logic eof);
         int             pos;
         int             pay_end;
         int             total;
         frame_word_type w;
         pos     = pos_count;
         pay_end = HdrBytes + int'(cap_len);
         if (pos < HdrBytes) begin
            case (pos)
               0: cap_version = b;
               1: cap_type = b;
               2: cap_seq = b;
               3: cap_cmd = b;
               4: cap_len[7:0] = b;
               default: cap_len[15:8] = b;
            endcase
            crc_acc = crc_update(crc_acc, b);
         end else if (pos < pay_end) begin
            crc_acc = crc_update(crc_acc, b);
         end else if (pos == pay_end) begin
            trailer_crc[7:0] = b;
         end else if (pos == pay_end + 1) begin
            trailer_crc[15:8] = b;
         end
         if (pos_count < int'(PosMax)) pos_count++;

         w.kind           = KIND_PAYLOAD;
         w.payload_byte   = '0;
         w.status         = STATUS_OK;
         w.version        = '0;
         w.msg_type       = '0;
         w.sequence_res   = '0;
         w.command        = '0;
         w.decl_length    = '0;

         if (!eof) begin
            if (pos >= HdrBytes && pos < pay_end && int'(cap_len) <= MaxPayload) begin
               w.payload_byte = b;
               expected_words.push_back(w);
            end
            return;
         end

         total = pos_count;
         if (total < HdrBytes + CrcBytes) w.status = STATUS_BAD_LEN;
         else if (int'(cap_len) > MaxPayload) w.status = STATUS_BAD_LEN;
         else if (total != HdrBytes + int'(cap_len) + CrcBytes) w.status = STATUS_BAD_LEN;
         else if (trailer_crc != crc_acc) w.status = STATUS_BAD_CRC;
         else w.status = STATUS_OK;
         w.kind           = KIND_FRAME;
         w.version        = cap_version;
         w.msg_type       = cap_type;
         w.sequence_res   = cap_seq;
         w.command        = cap_cmd;
         w.decl_length    = cap_len;
         expected_words.push_back(w);
         restart_frame();
      endfunction

      function void compare_field(string field, logic [15:0] exp_val, logic [15:0] got_val);
         if (exp_val !== got_val) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_val,
                     got_val);
         end
      endfunction

      function void check_word(frame_word_type got);
         frame_word_type exp_w;
         if (expected_words.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected word, expected none, got kind %0d", $time, got.kind);
            return;
         end
         exp_w = expected_words.pop_front();
         compare_field("result_kind", 16'(exp_w.kind), 16'(got.kind));
         compare_field("payload_byte", 16'(exp_w.payload_byte), 16'(got.payload_byte));
         compare_field("status", 16'(exp_w.status), 16'(got.status));
         compare_field("version", 16'(exp_w.version), 16'(got.version));
         compare_field("msg_type", 16'(exp_w.msg_type), 16'(got.msg_type));
         compare_field("sequence_res", 16'(exp_w.sequence_res), 16'(got.sequence_res));
         compare_field("command", 16'(exp_w.command), 16'(got.command));
         compare_field("decl_length", exp_w.decl_length, got.decl_length);
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        req_end_of_frame = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_result_kind;
   logic [7:0]  rsp_payload_byte;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_version;
   logic [7:0]  rsp_msg_type;
   logic [7:0]  rsp_sequence_res;
   logic [7:0]  rsp_command;
   logic [15:0] rsp_decl_length;

   frame_scoreboard sb = new();
   logic [7:0]      frame_bytes[$];
   int              burst_left = 0;
   int              bytes_sent = 0;

   stall_mode_type  stall_mode = STALL_NONE;
   int              stall_span = 0;
   logic [2:0]      pattern_count = '0;

   crc16_frame_checker_core #(
      .PAYLOAD_LIMIT(MaxPayload)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .req_end_of_frame(req_end_of_frame),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_kind(rsp_result_kind),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_status(rsp_status),
      .rsp_version(rsp_version),
      .rsp_msg_type(rsp_msg_type),
      .rsp_sequence_res(rsp_sequence_res),
      .rsp_command(rsp_command),
      .rsp_decl_length(rsp_decl_length)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_span <= $urandom_range(20, 200);
      end else begin
         stall_span <= stall_span - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= (pattern_count < 3'd3);
      endcase
      pattern_count <= pattern_count + 3'd1;
   end

   always @(posedge clock) begin
      frame_word_type got;
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_byte(req_rx_byte, req_end_of_frame);
         if (rsp_valid && !rsp_stall) begin
            got.kind           = kind_type'(rsp_result_kind);
            got.payload_byte   = rsp_payload_byte;
            got.status         = status_type'(rsp_status);
            got.version        = rsp_version;
            got.msg_type       = rsp_msg_type;
            got.sequence_res   = rsp_sequence_res;
            got.command        = rsp_command;
            got.decl_length    = rsp_decl_length;
            sb.check_word(got);
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IdleLimit) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b, input logic eof);
      int idle;
      if (burst_left <= 0) begin
         idle = $urandom_range(0, 8);
         if (idle > 0) begin
            req_valid <= 1'b0;
            repeat (idle) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 16);
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_rx_byte      <= b;
      req_end_of_frame <= eof;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_bytes.size(); i++)
         send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   // hold the sender off until every queued word has come back
   task automatic wait_all_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      burst_left = 0;
   endtask

   function automatic void build_frame(logic [7:0] ver, logic [7:0] ftype, logic [7:0] seq_no,
                                       logic [7:0] cmd, logic [15:0] decl_len, int n_pay,
                                       bit bad_crc);
      logic [15:0] crc;
      frame_bytes = {ver, ftype, seq_no, cmd, decl_len[7:0], decl_len[15:8]};
      for (int i = 0; i < n_pay; i++) frame_bytes.push_back(8'($urandom));
      crc = CrcInit;
      foreach (frame_bytes[i]) crc = frame_scoreboard::crc_update(crc, frame_bytes[i]);
      if (bad_crc) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      frame_bytes.push_back(crc[7:0]);
      frame_bytes.push_back(crc[15:8]);
   endfunction

   function automatic void build_random_frame(logic [15:0] decl_len, int n_pay, bit bad_crc);
      build_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), decl_len, n_pay,
                  bad_crc);
   endfunction

   function automatic int pick_good_length();
      return ($urandom_range(0, 24) == 0) ? $urandom_range(0, MaxPayload)
                                          : $urandom_range(0, 12);
   endfunction

   task automatic send_random_frame();
      int          pick;
      int          len;
      int          cut;
      logic [15:0] big_len;
      pick = $urandom_range(0, 99);
      len  = pick_good_length();
      if (pick < 50) begin
         build_random_frame(16'(len), len, 1'b0);
      end else if (pick < 62) begin
         build_random_frame(16'(len), len, 1'b1);
      end else if (pick < 70) begin
         big_len = ($urandom_range(0, 3) == 0) ? 16'(MaxPayload + 1)
                                               : 16'($urandom_range(MaxPayload + 1, 65535));
         build_random_frame(big_len, $urandom_range(0, 10), 1'b0);
      end else if (pick < 80) begin
         build_random_frame(16'(len), len, 1'b0);
         cut = $urandom_range(1, frame_bytes.size() - 1);
         while (frame_bytes.size() > cut) frame_bytes.delete(frame_bytes.size() - 1);
      end else if (pick < 92) begin
         build_random_frame(16'(len), len, 1'($urandom_range(0, 1)));
         repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
      end else begin
         frame_bytes.delete();
         repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom));
      end
      send_frame();
   endtask

   initial begin : stimulus
      int start_count;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // short frames, empty payload, eof on a payload byte
      frame_bytes = {8'hA5};
      send_frame();
      frame_bytes = {8'h01, 8'h02, 8'h03};
      send_frame();
      build_frame(8'hFF, 8'h00, 8'hFF, 8'h00, 16'd0, 0, 1'b0);
      send_frame();
      build_frame(8'h00, 8'hFF, 8'h00, 8'hFF, 16'd2, 2, 1'b0);
      frame_bytes.delete(frame_bytes.size() - 1);
      frame_bytes.delete(frame_bytes.size() - 1);
      frame_bytes.delete(frame_bytes.size() - 1);
      send_frame();
      build_frame(8'h7F, 8'h80, 8'h01, 8'hFE, 16'd1, 1, 1'b0);
      send_frame();

      // largest payload, one past it, and the largest declared length
      build_random_frame(16'(MaxPayload), MaxPayload, 1'b0);
      send_frame();
      build_random_frame(16'(MaxPayload + 1), 4, 1'b0);
      send_frame();
      build_random_frame(16'hFFFF, 3, 1'b0);
      send_frame();
      wait_all_results();

      start_count = bytes_sent;
      while (bytes_sent - start_count < RandomBytes) begin
         send_random_frame();
         if ($urandom_range(0, 11) == 0) wait_all_results();
      end
      wait_all_results();

      build_random_frame(16'd5, 5, 1'b0);
      send_frame();

      wait_all_results();
      repeat (DrainCycles) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
